[rtl/rnc_pkg.sv]
// Shared types, constants and helpers of the RTP NACK retransmit cache.
// Used by every module in rtl/; depends on nothing else.
package rnc_pkg;

    localparam int SLOT_W           = 10;
    localparam int SLOTS            = 1 << SLOT_W;
    localparam int SEQ_W            = 16;
    localparam int LEN_W            = 12;
    localparam int CNT_W            = 32;
    localparam int MASK_BITS        = 16;
    localparam int PT_W             = 7;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = LEN_W'(1316);

    localparam logic [1:0] FB_TRANSPORT = 2'd1;
    localparam logic [1:0] FB_PSFB      = 2'd2;

    localparam logic [4:0] NACK_FMT = 5'd1;
    localparam logic [4:0] PLI_FMT  = 5'd1;
    localparam logic [4:0] FIR_FMT  = 5'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_SSRC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYFRAME_EN   = 3'd4;

    localparam logic [PT_W-1:0] VIDEO_PT_RESET = 7'd96;

    typedef enum logic [1:0] {
        KIND_SEND     = 2'd0,
        KIND_RESEND   = 2'd1,
        KIND_KEYFRAME = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_SEND     = 2'd0,
        OP_NACK     = 2'd1,
        OP_KEYFRAME = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_READ  = 2'd1,
        BS_CMP   = 2'd2,
        BS_FLUSH = 2'd3
    } t_bstate;

    typedef struct packed {
        logic             action;
        logic             protect_ok;
        logic [7:0]       marker_and_type;
        logic [SEQ_W-1:0] sequence_number;
        logic [LEN_W-1:0] packet_length;
        logic [1:0]       fb_kind;
        logic [4:0]       fb_format;
        logic             fb_complete;
        logic [31:0]      media_ssrc;
        logic [SEQ_W-1:0] lost_base;
        logic [15:0]      lost_mask;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot_index;
        logic [SEQ_W-1:0]  seq_out;
        logic [LEN_W-1:0]  length_out;
        logic [CNT_W-1:0]  retransmit_total;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic              ring_en;
        logic [SLOT_W-1:0] slot_mask;
        logic [31:0]       video_ssrc;
        logic [PT_W-1:0]   video_pt;
        logic              keyframe_en;
    } t_cfg;

    typedef struct packed {
        t_op                  op;
        logic                 cache;
        logic [SLOT_W-1:0]    slot;
        logic [SEQ_W-1:0]     seq;
        logic [LEN_W-1:0]     len;
        logic [MASK_BITS-1:0] mask;
    } t_cmd;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_tag;

    function automatic logic [SLOT_W-1:0] slot_mask(input logic [3:0] size_log2);
        logic [3:0] eff;
        eff = (size_log2 > 4'(SLOT_W)) ? 4'(SLOT_W) : size_log2;
        return ~({SLOT_W{1'b1}} << eff);
    endfunction

endpackage

[rtl/rnc_cmd_queue.sv]
// Two-entry command queue between the classifier and the executor.
// Depends on rnc_pkg.
module rnc_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rnc_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rnc_pkg::t_cmd o_cmd
);

    rnc_pkg::t_cmd                       r_entry [rnc_pkg::QUEUE_DEPTH];
    logic [rnc_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [rnc_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [rnc_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [rnc_pkg::QUEUE_PTR_W-1:0]     n_wr_ptr;
    logic [rnc_pkg::QUEUE_PTR_W-1:0]     n_rd_ptr;
    logic [rnc_pkg::QUEUE_CNT_W-1:0]     n_count;
    logic                                w_push;
    logic                                w_pop;

    assign o_full  = (r_count == rnc_pkg::QUEUE_CNT_W'(rnc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == rnc_pkg::QUEUE_PTR_W'(rnc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == rnc_pkg::QUEUE_PTR_W'(rnc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[rtl/rnc_front.sv]
// Input classifier: decides drop, send, NACK or keyframe request per transaction.
// Depends on rnc_pkg; feeds rnc_cmd_queue.
module rnc_front (
    input  rnc_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    input  rnc_pkg::t_in_item i_in_data,
    input  logic              i_hold,
    output logic              o_in_stall,
    output logic              o_push,
    output rnc_pkg::t_cmd     o_cmd
);

    logic w_keep;
    logic w_cache;

    assign o_in_stall = i_hold;
    assign o_push     = i_in_valid && !i_hold && w_keep;

    assign w_cache = i_cfg.ring_en &&
                     (i_in_data.marker_and_type[rnc_pkg::PT_W-1:0] == i_cfg.video_pt) &&
                     (i_in_data.packet_length <= rnc_pkg::MAX_PACKET_BYTES);

    always_comb begin
        w_keep      = 1'b0;
        o_cmd.op    = rnc_pkg::OP_SEND;
        o_cmd.cache = 1'b0;
        o_cmd.slot  = '0;
        o_cmd.seq   = i_in_data.sequence_number;
        o_cmd.len   = i_in_data.packet_length;
        o_cmd.mask  = i_in_data.lost_mask;
        if (!i_in_data.action) begin
            w_keep      = i_in_data.protect_ok;
            o_cmd.cache = w_cache;
            if (w_cache) begin
                o_cmd.slot = i_in_data.sequence_number[rnc_pkg::SLOT_W-1:0] & i_cfg.slot_mask;
            end
        end else if (i_in_data.fb_kind == rnc_pkg::FB_PSFB) begin
            o_cmd.op = rnc_pkg::OP_KEYFRAME;
            w_keep   = i_cfg.keyframe_en &&
                       ((i_in_data.fb_format == rnc_pkg::PLI_FMT) ||
                        (i_in_data.fb_format == rnc_pkg::FIR_FMT));
        end else begin
            o_cmd.op  = rnc_pkg::OP_NACK;
            o_cmd.seq = i_in_data.lost_base;
            w_keep    = (i_in_data.fb_kind == rnc_pkg::FB_TRANSPORT) &&
                        (i_in_data.fb_format == rnc_pkg::NACK_FMT) &&
                        i_in_data.fb_complete &&
                        (i_in_data.media_ssrc == i_cfg.video_ssrc) &&
                        i_cfg.ring_en;
        end
    end

endmodule

[rtl/rnc_back.sv]
// Executor: slot tag memory, clearing pass, NACK walk and output register.
// Depends on rnc_pkg; drains rnc_cmd_queue.
module rnc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rnc_pkg::SLOT_W-1:0]    i_slot_mask,
    input  logic                          i_q_valid,
    input  rnc_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_clr_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rnc_pkg::t_out_item            o_out_data
);

    rnc_pkg::t_tag                     r_mem [rnc_pkg::SLOTS];
    rnc_pkg::t_tag                     r_rd_tag;

    rnc_pkg::t_bstate                  r_state;
    rnc_pkg::t_bstate                  n_state;
    logic                              r_clr_busy;
    logic                              n_clr_busy;
    logic [rnc_pkg::SLOT_W-1:0]        r_clr_addr;
    logic [rnc_pkg::SLOT_W-1:0]        n_clr_addr;
    logic [rnc_pkg::CNT_W-1:0]         r_cnt;
    logic [rnc_pkg::CNT_W-1:0]         n_cnt;
    logic                              r_out_valid;
    logic                              n_out_valid;
    rnc_pkg::t_out_item                r_out;
    rnc_pkg::t_out_item                n_out;
    logic                              r_pend_valid;
    logic                              n_pend_valid;
    rnc_pkg::t_out_item                r_pend;
    rnc_pkg::t_out_item                n_pend;
    logic [rnc_pkg::SEQ_W-1:0]         r_cand;
    logic [rnc_pkg::SEQ_W-1:0]         n_cand;
    logic [rnc_pkg::MASK_BITS:0]       r_flags;
    logic [rnc_pkg::MASK_BITS:0]       n_flags;

    logic                              w_out_free;
    logic                              w_hit;
    logic                              w_emit;
    rnc_pkg::t_out_item                w_emit_data;
    logic                              w_mem_we;
    logic [rnc_pkg::SLOT_W-1:0]        w_mem_wa;
    rnc_pkg::t_tag                     w_mem_wd;
    logic                              w_mem_re;
    logic [rnc_pkg::SLOT_W-1:0]        w_cand_slot;

    assign o_clr_busy  = r_clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cand_slot = r_cand[rnc_pkg::SLOT_W-1:0] & i_slot_mask;
    assign w_hit       = (r_rd_tag.len != '0) && (r_rd_tag.seq == r_cand);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rnc_pkg::BS_IDLE: begin
                if (!r_clr_busy && i_q_valid && (i_q_cmd.op == rnc_pkg::OP_NACK)) begin
                    n_state = rnc_pkg::BS_READ;
                end
            end
            rnc_pkg::BS_READ: begin
                if (r_flags == '0) begin
                    n_state = rnc_pkg::BS_FLUSH;
                end else if (r_flags[0]) begin
                    n_state = rnc_pkg::BS_CMP;
                end
            end
            rnc_pkg::BS_CMP: begin
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    n_state = rnc_pkg::BS_READ;
                end
            end
            rnc_pkg::BS_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = rnc_pkg::BS_IDLE;
                end
            end
            default: n_state = rnc_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        w_emit       = 1'b0;
        w_emit_data  = r_pend;
        w_mem_we     = 1'b0;
        w_mem_wa     = i_q_cmd.slot;
        w_mem_wd.seq = i_q_cmd.seq;
        w_mem_wd.len = i_q_cmd.len;
        w_mem_re     = 1'b0;
        n_clr_busy   = r_clr_busy;
        n_clr_addr   = r_clr_addr;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_cand       = r_cand;
        n_flags      = r_flags;

        if (r_clr_busy) begin
            w_mem_we   = 1'b1;
            w_mem_wa   = r_clr_addr;
            w_mem_wd   = '0;
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == {rnc_pkg::SLOT_W{1'b1}}) begin
                n_clr_busy = 1'b0;
            end
        end

        unique case (r_state)
            rnc_pkg::BS_IDLE: begin
                if (!r_clr_busy && i_q_valid) begin
                    case (i_q_cmd.op)
                        rnc_pkg::OP_NACK: begin
                            o_q_pop      = 1'b1;
                            n_cand       = i_q_cmd.seq;
                            n_flags      = {i_q_cmd.mask, 1'b1};
                            n_pend_valid = 1'b0;
                        end
                        rnc_pkg::OP_KEYFRAME: begin
                            if (w_out_free) begin
                                o_q_pop                      = 1'b1;
                                w_emit                       = 1'b1;
                                w_emit_data.kind             = rnc_pkg::KIND_KEYFRAME;
                                w_emit_data.slot_index       = '0;
                                w_emit_data.seq_out          = '0;
                                w_emit_data.length_out       = '0;
                                w_emit_data.retransmit_total = r_cnt;
                                w_emit_data.last             = 1'b1;
                            end
                        end
                        default: begin
                            if (w_out_free) begin
                                o_q_pop                      = 1'b1;
                                w_emit                       = 1'b1;
                                w_emit_data.kind             = rnc_pkg::KIND_SEND;
                                w_emit_data.slot_index       = i_q_cmd.slot;
                                w_emit_data.seq_out          = i_q_cmd.seq;
                                w_emit_data.length_out       = i_q_cmd.len;
                                w_emit_data.retransmit_total = r_cnt;
                                w_emit_data.last             = 1'b1;
                                w_mem_we                     = i_q_cmd.cache;
                            end
                        end
                    endcase
                end
            end
            rnc_pkg::BS_READ: begin
                if (r_flags != '0) begin
                    if (r_flags[0]) begin
                        w_mem_re = 1'b1;
                    end else begin
                        n_flags = r_flags >> 1;
                        n_cand  = r_cand + 1'b1;
                    end
                end
            end
            rnc_pkg::BS_CMP: begin
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    n_flags = r_flags >> 1;
                    n_cand  = r_cand + 1'b1;
                    if (w_hit) begin
                        w_emit                  = r_pend_valid;
                        w_emit_data.last        = 1'b0;
                        n_cnt                   = r_cnt + 1'b1;
                        n_pend_valid            = 1'b1;
                        n_pend.kind             = rnc_pkg::KIND_RESEND;
                        n_pend.slot_index       = w_cand_slot;
                        n_pend.seq_out          = r_cand;
                        n_pend.length_out       = r_rd_tag.len;
                        n_pend.retransmit_total = r_cnt + 1'b1;
                        n_pend.last             = 1'b0;
                    end
                end
            end
            rnc_pkg::BS_FLUSH: begin
                if (r_pend_valid && w_out_free) begin
                    w_emit           = 1'b1;
                    w_emit_data.last = 1'b1;
                    n_pend_valid     = 1'b0;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase

        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rnc_pkg::BS_IDLE;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_busy   <= n_clr_busy;
            r_clr_addr   <= n_clr_addr;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_pend  <= n_pend;
        r_cand  <= n_cand;
        r_flags <= n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_tag <= r_mem[w_cand_slot];
        end
    end

endmodule

[rtl/rtp_nack_retransmit_cache_unit.sv]
// Top level of the RTP NACK retransmit cache: configuration registers and wiring.
// Depends on rnc_pkg, rnc_front, rnc_cmd_queue and rnc_back.
//
// After reset the tag ring is swept clear, one slot a cycle; input transactions
// are stalled during the sweep while configuration writes are taken. Outbound
// packets and keyframe requests then go through at one transaction per cycle
// while the output is not stalled and no NACK is being walked. A generic NACK
// holds the back end while it steps through each mask position up to its
// highest flagged sequence and looks up the base sequence and each flagged one,
// each lookup being a registered memory read followed by a tag compare; a
// two-entry queue lets the input side keep accepting meanwhile. Output stall
// can hold the walk and its final flush.
module rtp_nack_retransmit_cache_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rnc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rnc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rnc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rnc_pkg::t_out_item                o_out_data
);

    logic                       r_ring_en;
    logic [3:0]                 r_ring_log2;
    logic [31:0]                r_video_ssrc;
    logic [rnc_pkg::PT_W-1:0]   r_video_pt;
    logic                       r_keyframe_en;

    rnc_pkg::t_cfg              w_cfg;
    logic                       w_push;
    rnc_pkg::t_cmd              w_push_cmd;
    logic                       w_q_full;
    logic                       w_q_valid;
    rnc_pkg::t_cmd              w_q_cmd;
    logic                       w_q_pop;
    logic                       w_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_en     <= 1'b0;
            r_ring_log2   <= '0;
            r_video_ssrc  <= '0;
            r_video_pt    <= rnc_pkg::VIDEO_PT_RESET;
            r_keyframe_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rnc_pkg::CFG_RING_ENABLE: r_ring_en     <= i_cfg_data[0];
                rnc_pkg::CFG_RING_SIZE:   r_ring_log2   <= i_cfg_data[3:0];
                rnc_pkg::CFG_VIDEO_SSRC:  r_video_ssrc  <= i_cfg_data[31:0];
                rnc_pkg::CFG_VIDEO_PT:    r_video_pt    <= i_cfg_data[rnc_pkg::PT_W-1:0];
                rnc_pkg::CFG_KEYFRAME_EN: r_keyframe_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_cfg.ring_en     = r_ring_en;
    assign w_cfg.slot_mask   = rnc_pkg::slot_mask(r_ring_log2);
    assign w_cfg.video_ssrc  = r_video_ssrc;
    assign w_cfg.video_pt    = r_video_pt;
    assign w_cfg.keyframe_en = r_keyframe_en;

    rnc_front u_front (
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_hold     (w_clr_busy || w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    rnc_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd)
    );

    rnc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot_mask (w_cfg.slot_mask),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_clr_busy  (w_clr_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
